// ----- hdl/sbr_pkg.sv -----
// Shared types and field widths for the stream byte reassembler.
package sbr_pkg;

	localparam int unsigned IDX_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SPACE_W = 7;
	localparam int unsigned PEND_W  = 7;

	// One input transfer: a byte at an absolute stream index, or a bare end marker
	typedef struct packed {
		logic [IDX_W-1:0]   stream_index;
		logic [BYTE_W-1:0]  data_byte;
		logic               has_byte;
		logic               ends_stream;
		logic [SPACE_W-1:0] space_available;
	} sbr_in_t;

	// One result transfer
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              last_of_run;
		logic              stream_closed;
		logic [PEND_W-1:0] pending_count;
	} sbr_out_t;

endpackage

// ----- hdl/stream_byte_reassembler_core.sv -----
// Stream byte reassembler: window store, release scan and result register.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one byte at an absolute
//   stream index, or a bare end marker. Result channel (res_valid/res_ready/
//   res_data) gives one transfer per released byte in stream order, or one
//   empty transfer (out_valid 0) when nothing is released; the final transfer
//   of each input has last_of_run set.
//   Sequence per input with the receiver ready: an accept step, an insert
//   step, a scan of the valid bits from the head, one slot per cycle, until
//   the run ends, then a memory read and a result load per released byte,
//   or one load for the empty result. The byte memory has a single read port.
//   The first result is visible the cycle after its load.
//   in_ready is high whenever no input is in progress, even while the last
//   result still waits in the output register.
//   Reset clears head, counts, end marker and all window valid bits at once;
//   the byte memory needs no clearing pass.
//   A stalled receiver holds the result register; the release sequence waits
//   and no further input is taken until the last transfer of the run is loaded.
module stream_byte_reassembler_core #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbr_pkg::sbr_in_t in_data,
	output logic             res_valid,
	input  logic             res_ready,
	output sbr_pkg::sbr_out_t res_data
);
	import sbr_pkg::*;

	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W  = SLOT_W + 1;
	localparam logic [SPACE_W-1:0] DEPTH_SP  = SPACE_W'(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
	localparam logic [SUM_W-1:0]   DEPTH_SUM = SUM_W'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_EMPTY,
		S_RD,
		S_WR
	} state_t;

	state_t              state_q;
	sbr_in_t             item_q;
	logic [CNT_W-1:0]    cap_q;
	logic [IDX_W-1:0]    head_q;
	logic [SLOT_W-1:0]   head_slot_q;
	logic [SLOT_W-1:0]   scan_slot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    stored_q;
	logic [CNT_W-1:0]    pending_q;
	logic                closed_q;
	logic                end_known_q;
	logic [IDX_W-1:0]    end_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [BYTE_W-1:0]   mem [WINDOW_DEPTH];
	logic [BYTE_W-1:0]   rd_q;
	logic                res_valid_q;
	sbr_out_t            res_q;

	logic [CNT_W-1:0]    cap_in;
	logic [IDX_W-1:0]    ins_off;
	logic                ins_ok;
	logic [SUM_W-1:0]    ins_sum;
	logic [SLOT_W-1:0]   ins_slot;
	logic                mem_we;
	logic                mem_re;
	logic                out_free;
	logic                res_load;
	logic                scan_go;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
		return r;
	endfunction

	// Window capacity for the incoming transfer
	assign cap_in = (in_data.space_available >= DEPTH_SP) ? DEPTH_CNT
		: in_data.space_available[CNT_W-1:0];

	// Insert decision: offset from head must fall inside the window
	assign ins_off  = item_q.stream_index - head_q;
	assign ins_ok   = item_q.has_byte && (item_q.stream_index >= head_q)
		&& (ins_off < IDX_W'(cap_q));
	assign ins_sum  = SUM_W'(head_slot_q) + SUM_W'(ins_off[SLOT_W-1:0]);
	assign ins_slot = (ins_sum >= DEPTH_SUM) ? SLOT_W'(ins_sum - DEPTH_SUM)
		: ins_sum[SLOT_W-1:0];

	assign mem_we   = (state_q == S_INS) && ins_ok && !valid_q[ins_slot];
	assign mem_re   = (state_q == S_RD);
	assign out_free = !res_valid_q || res_ready;
	assign res_load = ((state_q == S_EMPTY) || (state_q == S_WR)) && out_free;
	assign scan_go  = (cnt_q < cap_q) && valid_q[scan_slot_q];

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Byte store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ins_slot] <= item_q.data_byte;
		end
		if (mem_re) begin
			rd_q <= mem[head_slot_q];
		end
	end

	// Input payload and capacity capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
			cap_q  <= cap_in;
		end
	end

	// Control sequencer with window valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			head_slot_q <= '0;
			scan_slot_q <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			stored_q    <= '0;
			pending_q   <= '0;
			closed_q    <= 1'b0;
			end_known_q <= 1'b0;
			end_q       <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// result valid: set on load, cleared when the receiver takes it
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (mem_we) begin
						valid_q[ins_slot] <= 1'b1;
						stored_q          <= stored_q + CNT_W'(1);
					end
					if (item_q.ends_stream) begin
						end_known_q <= 1'b1;
						end_q       <= item_q.has_byte ? item_q.stream_index + IDX_W'(1)
							: item_q.stream_index;
					end
					scan_slot_q <= head_slot_q;
					cnt_q       <= '0;
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					// measure the contiguous run before any result goes out
					if (scan_go) begin
						cnt_q       <= cnt_q + CNT_W'(1);
						scan_slot_q <= slot_inc(scan_slot_q);
					end else begin
						closed_q  <= end_known_q && ((head_q + IDX_W'(cnt_q)) >= end_q);
						pending_q <= stored_q - cnt_q;
						stored_q  <= stored_q - cnt_q;
						rem_q     <= cnt_q;
						state_q   <= (cnt_q == '0) ? S_EMPTY : S_RD;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						res_q.out_byte      <= '0;
						res_q.out_valid     <= 1'b0;
						res_q.last_of_run   <= 1'b1;
						res_q.stream_closed <= closed_q;
						res_q.pending_count <= PEND_W'(pending_q);
						state_q             <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						res_q.out_byte       <= rd_q;
						res_q.out_valid      <= 1'b1;
						res_q.last_of_run    <= (rem_q == CNT_W'(1));
						res_q.stream_closed  <= closed_q;
						res_q.pending_count  <= PEND_W'(pending_q);
						valid_q[head_slot_q] <= 1'b0;
						head_slot_q          <= slot_inc(head_slot_q);
						head_q               <= head_q + IDX_W'(1);
						rem_q                <= rem_q - CNT_W'(1);
						state_q              <= (rem_q == CNT_W'(1)) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Stored count tracks the valid bits whenever no input is in flight
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(valid_q) == int'(stored_q)))
		else $error("stored count disagrees with window valid bits");

	// A released byte must come from an occupied slot
	a_release_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && out_free) |-> valid_q[head_slot_q])
		else $error("release from an empty window slot");

	// The run scan never passes the window capacity
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q <= cap_q))
		else $error("release run longer than capacity");

	// An empty result always closes its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.out_valid) |-> (res_q.last_of_run && res_q.out_byte == '0))
		else $error("empty result not marked last");

endmodule
